[design/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and codes of the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Request type codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_MODE    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_COUNT = 4'd1;

    // Fit mode codes
    localparam logic MODE_FIRST_FIT = 1'b0;
    localparam logic MODE_BEST_FIT  = 1'b1;

    localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  part_index;
        logic [15:0] size_value;
    } req_word_t;

    typedef struct packed {
        logic        fit_found;
        logic [3:0]  assigned_part;
        logic [15:0] assigned_size;
    } rsp_word_t;

endpackage

[design/fixed_partition_fit_allocator_core.sv]
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed partition allocator with first-fit and best-fit selection.
// ----------------------------------------------------------------------------
// Partition sizes live in a synchronous RAM; taken marks live in flip-flops
// cleared by reset. Load and clear words give no result. An allocate word
// reads the size RAM once per partition in use, one entry per cycle through
// its single read port. With N = min(block_count, MAX_PARTS) it holds
// req_stall high from the time it is taken through N reads, a compare of the
// last entry, a drain of the read pipe and the load of the output register.
// That load waits while an earlier result still sits in the output register,
// so no new request is taken until the previous allocate's result has been
// loaded. The result waits in the output register until the far side takes
// it.
// Sizes must be loaded for every partition in use before allocating.
module fixed_partition_fit_allocator_core #(
    parameter int MAX_PARTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ffpa_pkg::req_word_t                 req_word,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ffpa_pkg::rsp_word_t                 rsp_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ffpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ffpa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTS);
    localparam int CNT_W = $clog2(MAX_PARTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 fit_mode_reg, fit_mode_next;
    logic [4:0]           block_count_reg, block_count_next;
    logic [MAX_PARTS-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [SIZE_BITS-1:0] request_reg, request_next;
    logic                 pick_found_reg, pick_found_next;
    logic [IDX_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_word_t            out_word_reg, out_word_next;

    logic                 accept;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [SIZE_BITS-1:0] ram_rd_data;
    logic [CNT_W-1:0]     limit_now;
    logic                 fits;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    // Saturate the partition count to the table depth
    always_comb
    begin
        if (int'(block_count_reg) > MAX_PARTS)
        begin
            limit_now = CNT_W'(MAX_PARTS);
        end
        else
        begin
            limit_now = CNT_W'(block_count_reg);
        end
    end

    assign ram_wr_en = accept && (req_word.req_type == REQ_LOAD)
                       && (int'(req_word.part_index) < MAX_PARTS);

    assign fits = rd_valid_reg && !taken_reg[rd_idx_reg] && (ram_rd_data >= request_reg);

    ffpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTS)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (IDX_W'(req_word.part_index)),
        .wr_data (SIZE_BITS'(req_word.size_value)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        fit_mode_next    = fit_mode_reg;
        block_count_next = block_count_reg;
        taken_next       = taken_reg;
        limit_next       = limit_reg;
        iss_cnt_next     = iss_cnt_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        request_next     = request_reg;
        pick_found_next  = pick_found_reg;
        pick_idx_next    = pick_idx_reg;
        pick_size_next   = pick_size_reg;
        out_valid_next   = out_valid_reg && rsp_stall;
        out_word_next    = out_word_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = iss_cnt_reg[IDX_W-1:0];

        if (cfg_valid)
        begin
            if (cfg_index == CFG_FIT_MODE)
            begin
                fit_mode_next = cfg_data[0];
            end
            else if (cfg_index == CFG_BLOCK_COUNT)
            begin
                block_count_next = cfg_data[4:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_word.req_type == REQ_CLEAR)
                    begin
                        taken_next = '0;
                    end
                    else if (req_word.req_type == REQ_ALLOC)
                    begin
                        limit_next      = limit_now;
                        iss_cnt_next    = '0;
                        request_next    = SIZE_BITS'(req_word.size_value);
                        pick_found_next = 1'b0;
                        pick_idx_next   = '0;
                        pick_size_next  = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; compare the entry read last cycle
                if (iss_cnt_reg != limit_reg)
                begin
                    ram_rd_en     = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = iss_cnt_reg[IDX_W-1:0];
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_FINISH;
                end

                if (fits)
                begin
                    if (!pick_found_reg || ((fit_mode_reg == MODE_BEST_FIT)
                                            && (ram_rd_data < pick_size_reg)))
                    begin
                        pick_found_next = 1'b1;
                        pick_idx_next   = rd_idx_reg;
                        pick_size_next  = ram_rd_data;
                    end
                end
            end

            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next.fit_found     = pick_found_reg;
                    out_word_next.assigned_part = pick_found_reg ? 4'(pick_idx_reg) : 4'd0;
                    out_word_next.assigned_size = pick_found_reg ? 16'(pick_size_reg) : 16'd0;
                    if (pick_found_reg)
                    begin
                        taken_next[pick_idx_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fit_mode_reg    <= MODE_FIRST_FIT;
            block_count_reg <= BLOCK_COUNT_RESET;
            taken_reg       <= '0;
            iss_cnt_reg     <= '0;
            rd_valid_reg    <= 1'b0;
            pick_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fit_mode_reg    <= fit_mode_next;
            block_count_reg <= block_count_next;
            taken_reg       <= taken_next;
            iss_cnt_reg     <= iss_cnt_next;
            rd_valid_reg    <= rd_valid_next;
            pick_found_reg  <= pick_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        rd_idx_reg    <= rd_idx_next;
        request_reg   <= request_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        out_word_reg  <= out_word_next;
    end

endmodule

[design/ffpa_ram.sv]
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed partition fit allocator. Loads every
// partition, runs directed first-fit and best-fit cases, then random load,
// allocate and clear words under several register settings and handshake
// idling patterns. A partition book predicts each grant and checks the
// responses in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ffpa_pkg::*;

    localparam int PARTS = 16;
    localparam int IDLE_GAP = PARTS + 8;
    localparam int SEGMENTS = 12;
    localparam int SEGMENT_ITEMS = 100;
    localparam int MAX_REPORTS = 60;
    localparam longint RUN_LIMIT_NS = 5_000_000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [15:0] LOAD_SIZES [PARTS] = '{
        16'd100, 16'hFFFF, 16'd40, 16'd0, 16'd300, 16'd40, 16'h5555, 16'hAAAA,
        16'd60, 16'd70, 16'd80, 16'd90, 16'd120, 16'd150, 16'd200, 16'd250
    };
    localparam logic [4:0] SEGMENT_COUNTS [SEGMENTS] = '{
        5'd16, 5'd1, 5'd16, 5'd5, 5'd0, 5'd16, 5'd31, 5'd2, 5'd16, 5'd12, 5'd1, 5'd16
    };

    // Tracks sizes, taken marks and the grants still owed by the block.
    class partition_book;
        logic        mode;
        logic [4:0]  count;
        logic [15:0] sizes [PARTS];
        logic        taken [PARTS];
        rsp_word_t   due_grants [$];
        int          errors;

        function new();
            mode = MODE_FIRST_FIT;
            count = BLOCK_COUNT_RESET;
            foreach (sizes[i])
            begin
                sizes[i] = '0;
                taken[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_FIT_MODE)
                mode = data[0];
            else if (idx == CFG_BLOCK_COUNT)
                count = data[4:0];
        endfunction

        function void take_request(req_word_t w);
            int        limit;
            int        pick;
            logic      done;
            rsp_word_t grant;
            case (w.req_type)
                REQ_LOAD:
                    sizes[w.part_index] = w.size_value;
                REQ_CLEAR:
                    foreach (taken[i])
                        taken[i] = 1'b0;
                REQ_ALLOC:
                begin
                    limit = (count > PARTS) ? PARTS : int'(count);
                    pick = -1;
                    done = 1'b0;
                    for (int i = 0; i < limit; i++)
                    begin
                        if (!done && !taken[i] && sizes[i] >= w.size_value)
                        begin
                            if (pick < 0)
                            begin
                                pick = i;
                                // first fit stops at the first candidate
                                done = (mode == MODE_FIRST_FIT);
                            end
                            else if (sizes[i] < sizes[pick])
                            begin
                                pick = i;
                            end
                        end
                    end
                    grant = '0;
                    if (pick >= 0)
                    begin
                        taken[pick] = 1'b1;
                        grant.fit_found = 1'b1;
                        grant.assigned_part = 4'(pick);
                        grant.assigned_size = sizes[pick];
                    end
                    due_grants.push_back(grant);
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns mismatch: %s", $realtime, msg);
        endtask

        task match_grant(rsp_word_t got);
            rsp_word_t want;
            if (due_grants.size() == 0)
            begin
                report_mismatch($sformatf("word with none owed: found=%0b part=%0d size=%0h",
                                          got.fit_found, got.assigned_part,
                                          got.assigned_size));
                return;
            end
            want = due_grants.pop_front();
            if (got.fit_found !== want.fit_found)
                report_mismatch($sformatf("fit_found got %0b, want %0b",
                                          got.fit_found, want.fit_found));
            if (got.assigned_part !== want.assigned_part)
                report_mismatch($sformatf("assigned_part got %0d, want %0d",
                                          got.assigned_part, want.assigned_part));
            if (got.assigned_size !== want.assigned_size)
                report_mismatch($sformatf("assigned_size got %0h, want %0h",
                                          got.assigned_size, want.assigned_size));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    req_word_t                 req_word = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    rsp_word_t                 rsp_word;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int send_idle_pct = 6;
    int recv_stall_pct = 52;
    partition_book book;

    fixed_partition_fit_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.write_register(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                book.take_request(req_word);
            if (rsp_valid && !rsp_stall)
                book.match_grant(rsp_word);
        end
    end

    function automatic req_word_t make_word(logic [1:0] kind, logic [3:0] idx,
                                            logic [15:0] size);
        req_word_t w;
        w.req_type = kind;
        w.part_index = idx;
        w.size_value = size;
        return w;
    endfunction

    function automatic req_word_t random_word();
        req_word_t   w;
        int          pick;
        int          shape;
        logic [15:0] near;
        w = make_word(REQ_CLEAR, 4'($urandom_range(15)), 16'($urandom));
        pick = $urandom_range(99);
        shape = $urandom_range(99);
        near = book.sizes[$urandom_range(PARTS - 1)];
        if (pick < 45)
        begin
            w.req_type = REQ_ALLOC;
            // aim requests at existing sizes so that fits and ties happen
            if (shape < 40)
                w.size_value = near;
            else if (shape < 60)
                w.size_value = $urandom_range(1) ? near + 16'd1 : near - 16'd1;
            else if (shape < 75)
                w.size_value = '0;
            else if (shape < 90)
                w.size_value = 16'($urandom_range(511));
        end
        else if (pick < 75)
        begin
            w.req_type = REQ_LOAD;
            if (shape < 70)
                w.size_value = 16'($urandom_range(511));
            else if (shape < 80)
                w.size_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        else if (pick >= 90)
        begin
            w.req_type = REQ_UNUSED;
        end
        return w;
    endfunction

    task automatic send_request(input req_word_t w);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
            req_valid <= 1'b1;
            req_word <= w;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Drop valid, drain owed grants, then let a full scan's worth of cycles pass.
    task automatic settle_idle();
        begin
            req_valid <= 1'b0;
            while (book.due_grants.size() != 0)
                @(negedge clk);
            repeat (IDLE_GAP) @(negedge clk);
        end
    endtask

    task automatic apply_settings(input logic mode, input logic [4:0] count);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_FIT_MODE;
            cfg_data <= {15'd0, mode};
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_index <= CFG_BLOCK_COUNT;
            cfg_data <= {11'd0, count};
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        req_word_t w;
        int        left;
        book = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // every partition gets a size before any search can read it
        for (int i = 0; i < PARTS; i++)
            send_request(make_word(REQ_LOAD, 4'(i), LOAD_SIZES[i]));
        send_request(make_word(REQ_ALLOC, 4'hF, 16'h0000));
        send_request(make_word(REQ_ALLOC, 4'h0, 16'hFFFF));
        send_request(make_word(REQ_ALLOC, 4'h0, 16'hFFFF));
        send_request(make_word(REQ_UNUSED, 4'hF, 16'hFFFF));
        send_request(make_word(REQ_CLEAR, 4'h0, 16'h0000));
        send_request(make_word(REQ_ALLOC, 4'h0, 16'd50));
        settle_idle();
        apply_settings(MODE_BEST_FIT, 5'd16);
        // equal sizes: lower partition first, then the other one
        send_request(make_word(REQ_ALLOC, 4'h0, 16'd40));
        send_request(make_word(REQ_ALLOC, 4'h0, 16'd40));
        send_request(make_word(REQ_ALLOC, 4'h0, 16'h0000));
        send_request(make_word(REQ_ALLOC, 4'h0, 16'h5556));

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            settle_idle();
            apply_settings((seg % 2 == 0) ? MODE_FIRST_FIT : MODE_BEST_FIT,
                           SEGMENT_COUNTS[seg]);
            left = SEGMENT_ITEMS;
            while (left > 0)
            begin
                w = random_word();
                send_request(w);
                left--;
            end
        end

        settle_idle();
        if (book.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
